// ===== rtl/gft_pkg.sv =====
// package for the grammar file tokenizer: token kinds, scan modes, constants, result record
`timescale 1ns / 1ps
`default_nettype none
package gft_pkg;

  // default width of the line, column and length counters
  localparam int POSITION_WIDTH = 16;
  // width of the position and length fields on the result port
  localparam int OUT_W          = 16;
  localparam int CP_W           = 21;
  // entries in the result queue
  localparam int QUEUE_DEPTH    = 4;

  // token kinds as reported on the result port
  typedef enum logic [3:0] {
    K_UNDEF  = 4'd0,
    K_EOF    = 4'd1,
    K_IGNORE = 4'd2,
    K_EQ     = 4'd3,
    K_EOL    = 4'd4,
    K_ENTRY  = 4'd5,
    K_SPACE  = 4'd6,
    K_UPPER  = 4'd7,
    K_LOWER  = 4'd8,
    K_REGEX  = 4'd9,
    K_PRIO   = 4'd10
  } kind_t;

  // scanner modes: idle, and one or more per kind of open token
  typedef enum logic [3:0] {
    M_IDLE        = 4'd0,
    M_DOLLAR      = 4'd1,
    M_SPACE       = 4'd2,
    M_UPPER       = 4'd3,
    M_LOWER       = 4'd4,
    M_REGEX       = 4'd5,
    M_REGEX_ESC   = 4'd6,
    M_PRIO_OPEN   = 4'd7,
    M_PRIO_DIGITS = 4'd8
  } mode_t;

  // codepoints with a meaning of their own
  localparam logic [CP_W-1:0] CP_TAB    = 21'h09;
  localparam logic [CP_W-1:0] CP_LF     = 21'h0a;
  localparam logic [CP_W-1:0] CP_CR     = 21'h0d;
  localparam logic [CP_W-1:0] CP_SP     = 21'h20;
  localparam logic [CP_W-1:0] CP_BANG   = 21'h21;
  localparam logic [CP_W-1:0] CP_QUOTE  = 21'h22;
  localparam logic [CP_W-1:0] CP_DOLLAR = 21'h24;
  localparam logic [CP_W-1:0] CP_0      = 21'h30;
  localparam logic [CP_W-1:0] CP_9      = 21'h39;
  localparam logic [CP_W-1:0] CP_SEMI   = 21'h3b;
  localparam logic [CP_W-1:0] CP_LT     = 21'h3c;
  localparam logic [CP_W-1:0] CP_EQ     = 21'h3d;
  localparam logic [CP_W-1:0] CP_GT     = 21'h3e;
  localparam logic [CP_W-1:0] CP_UP_A   = 21'h41;
  localparam logic [CP_W-1:0] CP_UP_S   = 21'h53;
  localparam logic [CP_W-1:0] CP_UP_Z   = 21'h5a;
  localparam logic [CP_W-1:0] CP_BSLASH = 21'h5c;
  localparam logic [CP_W-1:0] CP_USCORE = 21'h5f;
  localparam logic [CP_W-1:0] CP_LO_A   = 21'h61;
  localparam logic [CP_W-1:0] CP_LO_Z   = 21'h7a;

  // one queued result
  typedef struct packed {
    kind_t            kind;
    logic [OUT_W-1:0] begin_line;
    logic [OUT_W-1:0] begin_column;
    logic [OUT_W-1:0] end_line;
    logic [OUT_W-1:0] end_column;
    logic [OUT_W-1:0] length;
    logic             last;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/grammar_file_tokenizer.sv =====
// grammar file tokenizer: one codepoint per transaction in, token records out
// a result is queued at the edge that accepts its codepoint; out_valid is high
//   while the queue holds any result
// throughput: one codepoint per cycle unless stalled; an item yields up to two
//   results, drained one per cycle while out_stall is low, through a four-entry
//   result queue that stalls the input when fewer than two entries are free
// reset: synchronous active-low rst_n clears mode, positions to 1, queue empty
`timescale 1ns / 1ps
`default_nettype none
module grammar_file_tokenizer #(
  parameter int POSITION_WIDTH = gft_pkg::POSITION_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration
  input  wire logic                     cfg_wr_en,
  input  wire logic                     cfg_wr_data,
  // codepoint input
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic [gft_pkg::CP_W-1:0] in_codepoint,
  input  wire logic                     in_end_of_input,
  // token output
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic [3:0]               out_token_kind,
  output      logic [gft_pkg::OUT_W-1:0] out_begin_line,
  output      logic [gft_pkg::OUT_W-1:0] out_begin_column,
  output      logic [gft_pkg::OUT_W-1:0] out_end_line,
  output      logic [gft_pkg::OUT_W-1:0] out_end_column,
  output      logic [gft_pkg::OUT_W-1:0] out_token_length,
  output      logic                     out_last_of_run
);

  localparam int P     = POSITION_WIDTH;
  localparam int DEPTH = gft_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // saturating increment of a position or length counter
  function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
    return (v == {P{1'b1}}) ? v : v + 1'b1;
  endfunction

  // build one result record from counter values
  function automatic gft_pkg::result_t mk_res(input gft_pkg::kind_t k,
                                               input logic [P-1:0] bl,
                                               input logic [P-1:0] bc,
                                               input logic [P-1:0] el,
                                               input logic [P-1:0] ec,
                                               input logic [P-1:0] len);
    gft_pkg::result_t r;
    r.kind         = k;
    r.begin_line   = gft_pkg::OUT_W'(bl);
    r.begin_column = gft_pkg::OUT_W'(bc);
    r.end_line     = gft_pkg::OUT_W'(el);
    r.end_column   = gft_pkg::OUT_W'(ec);
    r.length       = gft_pkg::OUT_W'(len);
    r.last         = 1'b0;
    return r;
  endfunction

  // scanner state
  gft_pkg::mode_t mode_r, mode_nxt;
  logic [P-1:0]   cl_r, cl_nxt;
  logic [P-1:0]   cc_r, cc_nxt;
  logic [P-1:0]   sl_r, sl_nxt;
  logic [P-1:0]   sc_r, sc_nxt;
  logic [P-1:0]   len_r, len_nxt;
  logic           drop_r;

  // result queue
  gft_pkg::result_t q_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  logic             in_acc, out_acc;
  logic [gft_pkg::CP_W-1:0] c;

  // codepoint classes
  logic is_sp, is_up, is_lo, is_dg, is_lf;
  logic [P-1:0] cl_c, cc_c;

  // begin-token decode
  logic             bt_emit;
  gft_pkg::kind_t   bt_kind;
  gft_pkg::mode_t   bt_mode;

  // the two possible results of one item
  logic             a_v, b_v, a_keep;
  gft_pkg::result_t a_res, b_res, slot0, slot1;
  logic [1:0]       n_push;
  logic             do_begin;

  assign in_stall = (cnt_r > CNT_W'(DEPTH - 2));
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign out_acc  = out_valid && !out_stall;
  assign c        = in_codepoint;

  // character classes, ASCII only
  assign is_sp = (c == gft_pkg::CP_SP) || (c >= gft_pkg::CP_TAB && c <= gft_pkg::CP_CR);
  assign is_up = (c >= gft_pkg::CP_UP_A) && (c <= gft_pkg::CP_UP_Z);
  assign is_lo = (c >= gft_pkg::CP_LO_A) && (c <= gft_pkg::CP_LO_Z);
  assign is_dg = (c >= gft_pkg::CP_0) && (c <= gft_pkg::CP_9);
  assign is_lf = (c == gft_pkg::CP_LF);

  // position after consuming the codepoint
  assign cl_c = is_lf ? sat_inc(cl_r) : cl_r;
  assign cc_c = is_lf ? P'(1) : sat_inc(cc_r);

  // what a codepoint does when it opens a token
  always_comb begin
    bt_emit = 1'b0;
    bt_kind = gft_pkg::K_UNDEF;
    bt_mode = gft_pkg::M_IDLE;
    if (c == gft_pkg::CP_BANG) begin
      bt_emit = 1'b1;
      bt_kind = gft_pkg::K_IGNORE;
    end else if (c == gft_pkg::CP_EQ) begin
      bt_emit = 1'b1;
      bt_kind = gft_pkg::K_EQ;
    end else if (c == gft_pkg::CP_SEMI) begin
      bt_emit = 1'b1;
      bt_kind = gft_pkg::K_EOL;
    end else if (c == gft_pkg::CP_DOLLAR) begin
      bt_mode = gft_pkg::M_DOLLAR;
    end else if (is_sp) begin
      bt_mode = gft_pkg::M_SPACE;
    end else if (is_up) begin
      bt_mode = gft_pkg::M_UPPER;
    end else if (is_lo) begin
      bt_mode = gft_pkg::M_LOWER;
    end else if (c == gft_pkg::CP_QUOTE) begin
      bt_mode = gft_pkg::M_REGEX;
    end else if (c == gft_pkg::CP_LT) begin
      bt_mode = gft_pkg::M_PRIO_OPEN;
    end else begin
      bt_emit = 1'b1;
    end
  end

  // scanner step: results and next state for the codepoint at the input
  always_comb begin
    mode_nxt = mode_r;
    cl_nxt   = cl_r;
    cc_nxt   = cc_r;
    sl_nxt   = sl_r;
    sc_nxt   = sc_r;
    len_nxt  = len_r;
    a_v      = 1'b0;
    b_v      = 1'b0;
    a_res    = mk_res(gft_pkg::K_UNDEF, sl_r, sc_r, cl_r, cc_r, len_r);
    b_res    = mk_res(gft_pkg::K_EOF, cl_r, cc_r, cl_r, cc_r, '0);
    do_begin = 1'b0;
    if (in_end_of_input) begin
      // flush the open token, then end-of-file, then positions back to 1
      a_v = (mode_r != gft_pkg::M_IDLE);
      case (mode_r)
        gft_pkg::M_SPACE: a_res.kind = gft_pkg::K_SPACE;
        gft_pkg::M_UPPER: a_res.kind = gft_pkg::K_UPPER;
        gft_pkg::M_LOWER: a_res.kind = gft_pkg::K_LOWER;
        default:          a_res.kind = gft_pkg::K_UNDEF;
      endcase
      b_v      = 1'b1;
      mode_nxt = gft_pkg::M_IDLE;
      cl_nxt   = P'(1);
      cc_nxt   = P'(1);
      sl_nxt   = P'(1);
      sc_nxt   = P'(1);
      len_nxt  = '0;
    end else begin
      case (mode_r)
        gft_pkg::M_DOLLAR: begin
          if (c == gft_pkg::CP_UP_S) begin
            a_v      = 1'b1;
            a_res    = mk_res(gft_pkg::K_ENTRY, sl_r, sc_r, cl_c, cc_c, sat_inc(len_r));
            mode_nxt = gft_pkg::M_IDLE;
            len_nxt  = '0;
            cl_nxt   = cl_c;
            cc_nxt   = cc_c;
          end else begin
            a_v      = 1'b1;
            do_begin = 1'b1;
          end
        end
        gft_pkg::M_SPACE: begin
          if (is_sp) begin
            cl_nxt  = cl_c;
            cc_nxt  = cc_c;
            len_nxt = sat_inc(len_r);
          end else begin
            a_v        = 1'b1;
            a_res.kind = gft_pkg::K_SPACE;
            do_begin   = 1'b1;
          end
        end
        gft_pkg::M_UPPER: begin
          if (is_up || is_dg || c == gft_pkg::CP_USCORE) begin
            cl_nxt  = cl_c;
            cc_nxt  = cc_c;
            len_nxt = sat_inc(len_r);
          end else begin
            a_v        = 1'b1;
            a_res.kind = gft_pkg::K_UPPER;
            do_begin   = 1'b1;
          end
        end
        gft_pkg::M_LOWER: begin
          if (is_lo || is_dg || c == gft_pkg::CP_USCORE) begin
            cl_nxt  = cl_c;
            cc_nxt  = cc_c;
            len_nxt = sat_inc(len_r);
          end else begin
            a_v        = 1'b1;
            a_res.kind = gft_pkg::K_LOWER;
            do_begin   = 1'b1;
          end
        end
        gft_pkg::M_REGEX: begin
          cl_nxt  = cl_c;
          cc_nxt  = cc_c;
          len_nxt = sat_inc(len_r);
          if (c == gft_pkg::CP_QUOTE) begin
            a_v      = 1'b1;
            a_res    = mk_res(gft_pkg::K_REGEX, sl_r, sc_r, cl_c, cc_c, sat_inc(len_r));
            mode_nxt = gft_pkg::M_IDLE;
            len_nxt  = '0;
          end else if (c == gft_pkg::CP_BSLASH) begin
            mode_nxt = gft_pkg::M_REGEX_ESC;
          end
        end
        gft_pkg::M_REGEX_ESC: begin
          cl_nxt   = cl_c;
          cc_nxt   = cc_c;
          len_nxt  = sat_inc(len_r);
          mode_nxt = gft_pkg::M_REGEX;
        end
        gft_pkg::M_PRIO_OPEN: begin
          if (is_dg) begin
            cl_nxt   = cl_c;
            cc_nxt   = cc_c;
            len_nxt  = sat_inc(len_r);
            mode_nxt = gft_pkg::M_PRIO_DIGITS;
          end else begin
            a_v      = 1'b1;
            do_begin = 1'b1;
          end
        end
        gft_pkg::M_PRIO_DIGITS: begin
          if (is_dg) begin
            cl_nxt  = cl_c;
            cc_nxt  = cc_c;
            len_nxt = sat_inc(len_r);
          end else if (c == gft_pkg::CP_GT) begin
            a_v      = 1'b1;
            a_res    = mk_res(gft_pkg::K_PRIO, sl_r, sc_r, cl_c, cc_c, sat_inc(len_r));
            mode_nxt = gft_pkg::M_IDLE;
            len_nxt  = '0;
            cl_nxt   = cl_c;
            cc_nxt   = cc_c;
          end else begin
            a_v      = 1'b1;
            do_begin = 1'b1;
          end
        end
        default: begin
          do_begin = 1'b1;
        end
      endcase
      // the codepoint opens a new token
      if (do_begin) begin
        sl_nxt   = cl_r;
        sc_nxt   = cc_r;
        cl_nxt   = cl_c;
        cc_nxt   = cc_c;
        b_v      = bt_emit;
        b_res    = mk_res(bt_kind, cl_r, cc_r, cl_c, cc_c, P'(1));
        mode_nxt = bt_emit ? gft_pkg::M_IDLE : bt_mode;
        len_nxt  = bt_emit ? '0 : P'(1);
      end
    end
  end

  // drop whitespace when asked, pack into queue slots and mark the last one
  always_comb begin
    a_keep = a_v && !(drop_r && a_res.kind == gft_pkg::K_SPACE);
    slot0  = a_keep ? a_res : b_res;
    slot1  = b_res;
    slot0.last = !(a_keep && b_v);
    slot1.last = 1'b1;
    n_push = 2'(a_keep) + 2'(b_v);
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= gft_pkg::M_IDLE;
      cl_r   <= P'(1);
      cc_r   <= P'(1);
      sl_r   <= P'(1);
      sc_r   <= P'(1);
      len_r  <= '0;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      cl_r   <= cl_nxt;
      cc_r   <= cc_nxt;
      sl_r   <= sl_nxt;
      sc_r   <= sc_nxt;
      len_r  <= len_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_r <= 1'b0;
    end else if (cfg_wr_en) begin
      drop_r <= cfg_wr_data;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_acc && n_push != 2'd0) begin
      q_r[wr_r] <= slot0;
    end
    if (in_acc && n_push == 2'd2) begin
      q_r[wr_r + 1'b1] <= slot1;
    end
  end

  // result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_acc) begin
        wr_r <= wr_r + PTR_W'(n_push);
      end
      if (out_acc) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (in_acc ? CNT_W'(n_push) : '0) - CNT_W'(out_acc);
    end
  end

  // head of the queue drives the result port
  assign out_token_kind   = q_r[rd_r].kind;
  assign out_begin_line   = q_r[rd_r].begin_line;
  assign out_begin_column = q_r[rd_r].begin_column;
  assign out_end_line     = q_r[rd_r].end_line;
  assign out_end_column   = q_r[rd_r].end_column;
  assign out_token_length = q_r[rd_r].length;
  assign out_last_of_run  = q_r[rd_r].last;

`ifndef NO_ASSERTIONS
  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("result queue over capacity");

  // an end transaction always leaves a result queued
  a_eof_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_end_of_input |=> cnt_r != '0)
    else $error("end of input produced no result");

  // an end transaction resets the position
  a_eof_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_end_of_input |=> (cl_r == P'(1) && cc_r == P'(1) && mode_r == gft_pkg::M_IDLE))
    else $error("position not reset after end of input");

  // end-of-file records carry zero length
  a_eof_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == gft_pkg::K_EOF |-> out_token_length == '0)
    else $error("end-of-file record with nonzero length");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/grammar_file_tokenizer_test.sv =====
// testbench for grammar_file_tokenizer: directed and random text checked against a token predictor
`timescale 1ns / 1ps
module grammar_file_tokenizer_test;
  import gft_pkg::*;

  localparam int unsigned      CP_LIMIT       = 1114111;
  localparam int               DRAIN_CYCLES   = 4;
  // the longest quiet stretch comes from the long receiver hold
  localparam int               WATCHDOG_LIMIT = 5000;
  localparam int               HOLD_CYCLES    = 300;
  localparam int               PRINT_LIMIT    = 100;
  localparam logic [OUT_W-1:0] POS_TOP        = '1;

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             cfg_wr_en       = 1'b0;
  logic             cfg_wr_data     = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_stall;
  logic [CP_W-1:0]  in_codepoint    = '0;
  logic             in_end_of_input = 1'b0;
  logic             out_valid;
  logic             out_stall       = 1'b0;
  logic [3:0]       out_token_kind;
  logic [OUT_W-1:0] out_begin_line;
  logic [OUT_W-1:0] out_begin_column;
  logic [OUT_W-1:0] out_end_line;
  logic [OUT_W-1:0] out_end_column;
  logic [OUT_W-1:0] out_token_length;
  logic             out_last_of_run;

  // scanner state mirrored by the token predictor
  mode_t            scan_state = M_IDLE;
  logic [OUT_W-1:0] line_now   = 1;
  logic [OUT_W-1:0] col_now    = 1;
  logic [OUT_W-1:0] tok_line   = 1;
  logic [OUT_W-1:0] tok_col    = 1;
  logic [OUT_W-1:0] tok_len    = 0;
  bit               drop_ws    = 1'b0;

  result_t step_tokens[$];
  result_t expected_tokens[$];
  result_t oldest_token;

  int mismatch_count     = 0;
  int quiet_cycles       = 0;
  int codepoints_sent    = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_cycles        = 0;

  grammar_file_tokenizer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_codepoint     (in_codepoint),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_begin_line   (out_begin_line),
    .out_begin_column (out_begin_column),
    .out_end_line     (out_end_line),
    .out_end_column   (out_end_column),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // character classes, ascii only
  function automatic bit is_blank(logic [CP_W-1:0] c);
    return c == CP_SP || (c >= CP_TAB && c <= CP_CR);
  endfunction

  function automatic bit is_digit(logic [CP_W-1:0] c);
    return c >= CP_0 && c <= CP_9;
  endfunction

  function automatic bit is_upper_letter(logic [CP_W-1:0] c);
    return c >= CP_UP_A && c <= CP_UP_Z;
  endfunction

  function automatic bit is_lower_letter(logic [CP_W-1:0] c);
    return c >= CP_LO_A && c <= CP_LO_Z;
  endfunction

  function automatic logic [OUT_W-1:0] bump(logic [OUT_W-1:0] v);
    return (v == POS_TOP) ? v : v + 1'b1;
  endfunction

  // advance position and token length over one codepoint
  function automatic void take_codepoint(logic [CP_W-1:0] c);
    col_now = bump(col_now);
    if (c == CP_LF) begin
      col_now  = 1;
      line_now = bump(line_now);
    end
    tok_len = bump(tok_len);
  endfunction

  // close the open token; whitespace may be dropped
  function automatic void emit_token(kind_t kind);
    result_t tok;
    if (!(kind == K_SPACE && drop_ws)) begin
      tok.kind         = kind;
      tok.begin_line   = tok_line;
      tok.begin_column = tok_col;
      tok.end_line     = line_now;
      tok.end_column   = col_now;
      tok.length       = tok_len;
      tok.last         = 1'b0;
      step_tokens.push_back(tok);
    end
    scan_state = M_IDLE;
    tok_len    = '0;
  endfunction

  function automatic void open_token(logic [CP_W-1:0] c);
    tok_line = line_now;
    tok_col  = col_now;
    tok_len  = '0;
    take_codepoint(c);
    if (c == CP_BANG) emit_token(K_IGNORE);
    else if (c == CP_EQ) emit_token(K_EQ);
    else if (c == CP_SEMI) emit_token(K_EOL);
    else if (c == CP_DOLLAR) scan_state = M_DOLLAR;
    else if (is_blank(c)) scan_state = M_SPACE;
    else if (is_upper_letter(c)) scan_state = M_UPPER;
    else if (is_lower_letter(c)) scan_state = M_LOWER;
    else if (c == CP_QUOTE) scan_state = M_REGEX;
    else if (c == CP_LT) scan_state = M_PRIO_OPEN;
    else emit_token(K_UNDEF);
  endfunction

  // the breaking codepoint starts the next token
  function automatic void close_and_restart(kind_t kind, logic [CP_W-1:0] c);
    emit_token(kind);
    open_token(c);
  endfunction

  function automatic void scan_codepoint(logic [CP_W-1:0] c);
    case (scan_state)
      M_DOLLAR: begin
        if (c == CP_UP_S) begin
          take_codepoint(c);
          emit_token(K_ENTRY);
        end else begin
          close_and_restart(K_UNDEF, c);
        end
      end
      M_SPACE: begin
        if (is_blank(c)) take_codepoint(c);
        else close_and_restart(K_SPACE, c);
      end
      M_UPPER: begin
        if (is_upper_letter(c) || is_digit(c) || c == CP_USCORE) take_codepoint(c);
        else close_and_restart(K_UPPER, c);
      end
      M_LOWER: begin
        if (is_lower_letter(c) || is_digit(c) || c == CP_USCORE) take_codepoint(c);
        else close_and_restart(K_LOWER, c);
      end
      M_REGEX: begin
        take_codepoint(c);
        if (c == CP_QUOTE) emit_token(K_REGEX);
        else if (c == CP_BSLASH) scan_state = M_REGEX_ESC;
      end
      M_REGEX_ESC: begin
        take_codepoint(c);
        scan_state = M_REGEX;
      end
      M_PRIO_OPEN: begin
        if (is_digit(c)) begin
          take_codepoint(c);
          scan_state = M_PRIO_DIGITS;
        end else begin
          close_and_restart(K_UNDEF, c);
        end
      end
      M_PRIO_DIGITS: begin
        if (is_digit(c)) begin
          take_codepoint(c);
        end else if (c == CP_GT) begin
          take_codepoint(c);
          emit_token(K_PRIO);
        end else begin
          close_and_restart(K_UNDEF, c);
        end
      end
      default: open_token(c);
    endcase
  endfunction

  // end of text: flush, report eof, rewind positions
  function automatic void close_text();
    case (scan_state)
      M_IDLE: ;
      M_SPACE: emit_token(K_SPACE);
      M_UPPER: emit_token(K_UPPER);
      M_LOWER: emit_token(K_LOWER);
      default: emit_token(K_UNDEF);
    endcase
    tok_line = line_now;
    tok_col  = col_now;
    tok_len  = '0;
    emit_token(K_EOF);
    line_now = 1;
    col_now  = 1;
    tok_line = 1;
    tok_col  = 1;
  endfunction

  function automatic void predict_tokens(logic [CP_W-1:0] cp, bit eoi);
    step_tokens.delete();
    if (eoi) close_text();
    else scan_codepoint(cp);
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // random codepoint pickers
  function automatic int unsigned any_codepoint();
    case ($urandom_range(3))
      0: return $urandom_range(CP_LIMIT);
      1: return $urandom_range(255);
      default: return $urandom_range(32, 126);
    endcase
  endfunction

  function automatic int unsigned blank_char();
    int unsigned r;
    r = $urandom_range(5);
    return (r == 5) ? CP_SP : CP_TAB + r;
  endfunction

  function automatic int unsigned word_char(bit upper);
    int unsigned r;
    r = $urandom_range(37);
    if (r < 26) return (upper ? CP_UP_A : CP_LO_A) + r;
    if (r < 36) return CP_0 + r - 26;
    return CP_USCORE;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t token check %s: got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  // one codepoint transaction; called and returns at a rising edge
  task automatic send_codepoint(input int unsigned cp, input bit eoi);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_codepoint    <= cp[CP_W-1:0];
    in_end_of_input <= eoi;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    predict_tokens(cp[CP_W-1:0], eoi);
    codepoints_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_codepoint(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_codepoint($urandom_range(CP_LIMIT), 1'b1);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_drop_whitespace(input bit value);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    drop_ws = value;
  endtask

  // mostly well-formed tokens with random content, some noise and broken tokens
  task automatic send_random_tokens(input int goal);
    int          stop_at;
    int unsigned pick;
    stop_at = codepoints_sent + goal;
    while (codepoints_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        case ($urandom_range(2))
          0: send_codepoint(CP_BANG, 1'b0);
          1: send_codepoint(CP_EQ, 1'b0);
          default: send_codepoint(CP_SEMI, 1'b0);
        endcase
      end else if (pick < 15) begin
        send_codepoint(CP_DOLLAR, 1'b0);
        send_codepoint(CP_UP_S, 1'b0);
      end else if (pick < 18) begin
        send_codepoint(CP_DOLLAR, 1'b0);
        send_codepoint(any_codepoint(), 1'b0);
      end else if (pick < 30) begin
        repeat ($urandom_range(1, 6)) send_codepoint(blank_char(), 1'b0);
      end else if (pick < 42) begin
        send_codepoint(CP_UP_A + $urandom_range(25), 1'b0);
        repeat ($urandom_range(0, 5)) send_codepoint(word_char(1'b1), 1'b0);
      end else if (pick < 56) begin
        send_codepoint(CP_LO_A + $urandom_range(25), 1'b0);
        repeat ($urandom_range(0, 5)) send_codepoint(word_char(1'b0), 1'b0);
      end else if (pick < 68) begin
        send_codepoint(CP_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(3) == 0) begin
            send_codepoint(CP_BSLASH, 1'b0);
            send_codepoint($urandom_range(1) ? CP_QUOTE : any_codepoint(), 1'b0);
          end else begin
            send_codepoint(any_codepoint(), 1'b0);
          end
        end
        if ($urandom_range(9) != 0) send_codepoint(CP_QUOTE, 1'b0);
      end else if (pick < 78) begin
        send_codepoint(CP_LT, 1'b0);
        repeat ($urandom_range(0, 4)) send_codepoint(CP_0 + $urandom_range(9), 1'b0);
        if ($urandom_range(6) != 0) send_codepoint(CP_GT, 1'b0);
      end else if (pick < 95) begin
        send_codepoint(any_codepoint(), 1'b0);
      end else begin
        send_end();
      end
    end
  endtask

  task automatic test_punctuation();
    set_idling(0, 0);
    send_text("!=;$S$x");
    send_end();
  endtask

  task automatic test_words_and_tags();
    set_idling(28, 28);
    send_text("A_9\t\nb<3>\"\\\"\"");
    send_end();
  endtask

  // zero, top codepoint, lone angle bracket, regex left open on a backslash
  task automatic test_odd_codepoints();
    set_idling(0, 0);
    send_codepoint(0, 1'b0);
    send_codepoint(CP_LIMIT, 1'b0);
    send_text("< \"\\");
    send_end();
  endtask

  task automatic test_drop_whitespace();
    write_drop_whitespace(1'b1);
    set_idling(0, 0);
    send_text(" a ");
    send_end();
    write_drop_whitespace(1'b0);
  endtask

  // receiver holds off while single-codepoint tokens keep coming
  task automatic test_back_pressure();
    set_idling(0, 0);
    hold_cycles = HOLD_CYCLES;
    repeat (12) send_text("!=;");
    wait_for_drain();
  endtask

  task automatic test_random_text(input int sender_pct, input int receiver_pct,
                                  input bit drop, input int goal);
    write_drop_whitespace(drop);
    set_idling(sender_pct, receiver_pct);
    send_random_tokens(goal);
    send_end();
  endtask

  // receiver stall, with an optional long hold
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // result check, decided before the edge that takes the transaction
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected token kind", out_token_kind, 0);
      end else begin
        oldest_token = expected_tokens.pop_front();
        if (out_token_kind !== oldest_token.kind)
          report_mismatch("token_kind", out_token_kind, oldest_token.kind);
        if (out_begin_line !== oldest_token.begin_line)
          report_mismatch("begin_line", out_begin_line, oldest_token.begin_line);
        if (out_begin_column !== oldest_token.begin_column)
          report_mismatch("begin_column", out_begin_column, oldest_token.begin_column);
        if (out_end_line !== oldest_token.end_line)
          report_mismatch("end_line", out_end_line, oldest_token.end_line);
        if (out_end_column !== oldest_token.end_column)
          report_mismatch("end_column", out_end_column, oldest_token.end_column);
        if (out_token_length !== oldest_token.length)
          report_mismatch("token_length", out_token_length, oldest_token.length);
        if (out_last_of_run !== oldest_token.last)
          report_mismatch("last_of_run", out_last_of_run, oldest_token.last);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_punctuation();
    test_words_and_tags();
    test_odd_codepoints();
    test_drop_whitespace();
    test_back_pressure();
    test_random_text(0, 0, 1'b0, 375);
    test_random_text(50, 0, 1'b1, 375);
    test_random_text(0, 50, 1'b0, 375);
    test_random_text(28, 28, 1'b1, 375);

    wait_for_drain();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
